/* rtl/pts_pkg.sv */
`default_nettype none

package pts_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 64;

  // Operation codes carried on the command channel.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_REG   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNREG = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_PERIOD = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY       = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RANGE       = 3'd4;

  // What the token asks of each cell as it passes.
  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_TICK,
    TOK_REG,
    TOK_UNREG
  } tok_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_t;

  // Token handed from cell to cell, one cell per cycle while the row advances.
  typedef struct packed {
    logic                valid;
    tok_op_t             op;
    logic [PERIOD_W-1:0] period;
    logic                rep;
    logic [TAG_W-1:0]    tag;
    logic [SLOT_W-1:0]   index;
    logic                claimed;
  } token_t;

  // Result offered by the cell that currently holds the token. A pushed
  // result is one more firing; an unpushed one replaces the preset answer.
  typedef struct packed {
    logic                valid;
    logic                push;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                fired;
    logic [TAG_W-1:0]    tag;
  } cell_res_t;

endpackage

`default_nettype wire

/* rtl/pts_if.sv */
`default_nettype none

interface pts_cmd_if
  import pts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [PERIOD_W-1:0] period;
  logic                repeat_mode;
  logic [TAG_W-1:0]    tag;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, operation, period, repeat_mode, tag, slot_index,
                  input ready);
  modport sink (input valid, operation, period, repeat_mode, tag, slot_index,
                output ready);
endinterface

interface pts_res_if
  import pts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                fired;
  logic [TAG_W-1:0]    fired_tag;
  logic [COUNT_W-1:0]  now;
  logic                last;

  modport source (output valid, status, slot, fired, fired_tag, now, last,
                  input ready);
  modport sink (input valid, status, slot, fired, fired_tag, now, last,
                output ready);
endinterface

`default_nettype wire

/* rtl/pts_cell.sv */
`default_nettype none

module pts_cell
  import pts_pkg::*;
#(
  parameter int unsigned CELL_ID = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [COUNT_W-1:0] now,
  input  wire token_t             tok_in,
  output token_t                  tok_out,
  output cell_res_t               res
);

  logic                active;
  logic [COUNT_W-1:0]  deadline;
  logic [PERIOD_W-1:0] period;
  logic                rep;
  logic [TAG_W-1:0]    tag;

  token_t              tok_next;
  logic                fire;
  logic                claim;
  logic                release_slot;
  logic [COUNT_W-1:0]  deadline_next;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_ID);

  always_comb begin
    tok_next     = tok_in;
    res          = '0;
    fire         = 1'b0;
    claim        = 1'b0;
    release_slot = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.op)
        TOK_TICK: begin
          fire = active && (deadline < now);
        end
        TOK_REG: begin
          claim = !tok_in.claimed && !active;
        end
        TOK_UNREG: begin
          release_slot = (tok_in.index == MY_SLOT) && active;
        end
        default: begin
        end
      endcase
    end
    if (claim) begin
      tok_next.claimed = 1'b1;
    end
    res.valid  = fire || claim || release_slot;
    res.push   = fire;
    res.status = STAT_OK;
    res.slot   = res.valid ? MY_SLOT : '0;
    res.fired  = fire;
    res.tag    = fire ? tag : '0;
    // One adder serves both the claim and the re-arm.
    deadline_next = now + {{(COUNT_W-PERIOD_W){1'b0}}, claim ? tok_in.period : period};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (claim) begin
        active <= 1'b1;
      end else if (release_slot || (fire && !rep)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (claim) begin
        period <= tok_in.period;
        rep    <= tok_in.rep;
        tag    <= tok_in.tag;
      end
      if (claim || (fire && rep)) begin
        deadline <= deadline_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/periodic_timeout_slot_table_top.sv */
`default_nettype none

// Periodic timeout slot table.
//
// Commands arrive on the cmd channel and results leave on the res channel,
// both valid/ready; a beat moves at a rising edge with valid and ready high.
// A tick command advances the 64-bit tick counter and reports every slot
// whose deadline has passed, one result beat per firing slot in ascending
// slot order. A register command claims the lowest free slot; an unregister
// command frees one. Both give exactly one result beat. A quiet tick and the
// unused operation code give none. The last beat of each command has last set.
//
// Each slot lives in its own cell of a row of SLOTS cells. A token carrying
// the command walks the row one cell per clock while the row is not stalled.
// A command occupies the block while the token is loaded, while it visits
// the cells and while the final beat is handed over. cmd.ready is low
// during that walk. The unused operation code is accepted but starts no walk.
//
// When the receiver stalls, a finished beat waits in the output register and
// one more in a holding register; the token then pauses in place, so nothing
// is lost. Reset frees every slot, zeroes the counter and empties the row.
module periodic_timeout_slot_table_top
  import pts_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pts_cmd_if.sink    cmd,
  pts_res_if.source  res
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic [COUNT_W-1:0] tick_count;

  // Token waiting to enter the first cell, and the row's token registers.
  token_t    tok0;
  token_t    tok_chain [SLOTS+1];
  cell_res_t cres_arr  [SLOTS];
  cell_res_t cres;
  logic [SLOTS:0] tok_valids;

  logic advance;
  logic cmd_ready;
  logic accept;
  logic op_known;
  logic end_valid;
  logic out_busy;
  logic load_out;

  // Holding register: the most recent result, not yet known to be the last.
  logic                pend_valid;
  logic [STATUS_W-1:0] pend_status;
  logic [SLOT_W-1:0]   pend_slot;
  logic                pend_fired;
  logic [TAG_W-1:0]    pend_tag;

  // Output register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_fired;
  logic [TAG_W-1:0]    out_tag;
  logic [COUNT_W-1:0]  out_now;
  logic                out_last;

  assign tok_chain[0] = tok0;
  assign end_valid    = tok_chain[SLOTS].valid;
  assign accept       = cmd.valid && cmd_ready;
  assign out_busy     = out_valid && !res.ready;

  // Only the three defined operations start a walk along the row.
  assign op_known = (cmd.operation == OP_TICK) || (cmd.operation == OP_REG) ||
                    (cmd.operation == OP_UNREG);

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      pts_cell #(
        .CELL_ID (g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .now     (tick_count),
        .tok_in  (tok_chain[g]),
        .tok_out (tok_chain[g+1]),
        .res     (cres_arr[g])
      );
    end
  endgenerate

  // Only the cell holding the token drives a non-zero result.
  always_comb begin
    cres = '0;
    for (int k = 0; k < SLOTS; k++) begin
      cres = cres | cres_arr[k];
    end
    for (int k = 0; k <= SLOTS; k++) begin
      tok_valids[k] = tok_chain[k].valid;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    advance    = 1'b1;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (accept && op_known) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A new firing or the final hand-over needs the output register free.
        if (pend_valid && out_busy && ((cres.valid && cres.push) || end_valid)) begin
          advance = 1'b0;
        end
        if (end_valid && advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign load_out  = advance && pend_valid && ((cres.valid && cres.push) || end_valid);
  assign cmd.ready = cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counter and the valid flags of the two result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
      if (accept) begin
        case (cmd.operation)
          OP_TICK: begin
            tick_count <= tick_count + COUNT_W'(1);
            pend_valid <= 1'b0;
          end
          OP_REG, OP_UNREG: begin
            pend_valid <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (advance) begin
        if (cres.valid) begin
          pend_valid <= 1'b1;
        end else if (end_valid) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  // Token injection and the payload of the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.valid <= 1'b0;
    end else if (accept) begin
      tok0.valid <= op_known;
    end else if (advance) begin
      tok0.valid <= 1'b0;
    end
    if (accept) begin
      tok0.period  <= cmd.period;
      tok0.rep     <= cmd.repeat_mode;
      tok0.tag     <= cmd.tag;
      tok0.index   <= cmd.slot_index;
      tok0.claimed <= 1'b0;
      tok0.op      <= TOK_NONE;
      pend_slot    <= '0;
      pend_fired   <= 1'b0;
      pend_tag     <= '0;
      // Register and unregister preset the error answer; the cell that
      // acts on the command overwrites it.
      case (cmd.operation)
        OP_TICK: begin
          tok0.op <= TOK_TICK;
        end
        OP_REG: begin
          if (cmd.period == '0) begin
            pend_status <= STAT_ZERO_PERIOD;
          end else begin
            pend_status <= STAT_FULL;
            tok0.op     <= TOK_REG;
          end
        end
        OP_UNREG: begin
          if ({1'b0, cmd.slot_index} >= (SLOT_W+1)'(SLOTS)) begin
            pend_status <= STAT_RANGE;
          end else begin
            pend_status <= STAT_EMPTY;
            tok0.op     <= TOK_UNREG;
          end
        end
        default: begin
        end
      endcase
    end else if (advance && cres.valid) begin
      pend_status <= cres.status;
      pend_slot   <= cres.slot;
      pend_fired  <= cres.fired;
      pend_tag    <= cres.tag;
    end
    if (load_out) begin
      out_status <= pend_status;
      out_slot   <= pend_slot;
      out_fired  <= pend_fired;
      out_tag    <= pend_tag;
      out_now    <= tick_count;
      out_last   <= end_valid;
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.slot      = out_slot;
  assign res.fired     = out_fired;
  assign res.fired_tag = out_tag;
  assign res.now       = out_now;
  assign res.last      = out_last;

  // The row never holds more than one token.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one token in the slot row");

  // Between commands nothing is left in the holding register.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left behind after a command");

  // The counter moves only on an accepted tick.
  a_count_hold: assert property (@(posedge clk)
    (!rst && !(accept && (cmd.operation == OP_TICK))) |=> (rst || $stable(tick_count)))
    else $error("tick counter moved without a tick");

  // A command ends only with the row left entirely empty, last cell included.
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && state_next == ST_IDLE) |=> (tok_valids == '0))
    else $error("token still in the row after the scan ended");

endmodule

`default_nettype wire
